FILE: sv/lqm_pkg.sv
// Shared types, codes and sizes for the linked queue manager.
package lqm_pkg;

  localparam int NumElems  = 64;
  localparam int NumQueues = 4;
  localparam int ElemW     = $clog2(NumElems);
  localparam int QueueW    = $clog2(NumQueues);
  localparam int LenW      = $clog2(NumElems + 1);

  typedef logic [ElemW-1:0]  elem_t;
  typedef logic [QueueW-1:0] queue_t;
  typedef logic [LenW-1:0]   len_t;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SIZE   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_LINKED = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_ABSENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LINK = 2'd2,
    ST_RESP = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    queue_t     queue_id;
    elem_t      elem_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    len_t       queue_length;
    elem_t      head_elem;
    logic       head_valid;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic link;
    logic resp;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_link;
    logic out_busy;
  } sts_t;

endpackage

FILE: sv/lqm_ctrl.sv
// Request sequencer for the linked queue manager.
module lqm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lqm_pkg::sts_t  sts_i,
  output lqm_pkg::cmd_t  cmd_o
);

  lqm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lqm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lqm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lqm_pkg::ST_EXEC;
      end
      lqm_pkg::ST_EXEC: begin
        state_d = sts_i.need_link ? lqm_pkg::ST_LINK : lqm_pkg::ST_RESP;
      end
      lqm_pkg::ST_LINK: begin
        state_d = lqm_pkg::ST_RESP;
      end
      lqm_pkg::ST_RESP: begin
        if (!sts_i.out_busy) state_d = lqm_pkg::ST_IDLE;
      end
      default: state_d = lqm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != lqm_pkg::ST_IDLE);
    cmd_o.load = (state_q == lqm_pkg::ST_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == lqm_pkg::ST_EXEC);
    cmd_o.link = (state_q == lqm_pkg::ST_LINK);
    cmd_o.resp = (state_q == lqm_pkg::ST_RESP) && !sts_i.out_busy;
  end

endmodule

FILE: sv/lqm_dpath.sv
// Link memories, queue descriptors and result register of the linked queue manager.
module lqm_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lqm_pkg::in_word_t   in_word_i,
  input  lqm_pkg::cmd_t       cmd_i,
  output lqm_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lqm_pkg::out_word_t  out_word_o
);

  // latched request
  logic [1:0]      req_q;
  lqm_pkg::queue_t qid_q;
  lqm_pkg::elem_t  eid_q;

  // per-element state
  lqm_pkg::elem_t  next_mem  [lqm_pkg::NumElems];
  lqm_pkg::elem_t  prev_mem  [lqm_pkg::NumElems];
  lqm_pkg::queue_t owner_mem [lqm_pkg::NumElems];
  logic [lqm_pkg::NumElems-1:0] linked_q;
  lqm_pkg::elem_t  next_rd_q, prev_rd_q;
  lqm_pkg::queue_t owner_rd_q;

  // per-queue descriptors
  lqm_pkg::elem_t  head_q    [lqm_pkg::NumQueues];
  logic [lqm_pkg::NumQueues-1:0] present_q;
  lqm_pkg::len_t   len_q     [lqm_pkg::NumQueues];

  logic [1:0]      status_q, status_d;
  logic            out_valid_q;
  lqm_pkg::out_word_t out_q;

  logic            cur_present, cur_linked;
  lqm_pkg::elem_t  cur_head;
  lqm_pkg::len_t   cur_len;

  logic            nx_we, pv_we, ow_we;
  lqm_pkg::elem_t  nx_wa, nx_wd, pv_wa, pv_wd, prev_ra;
  logic            linked_set, linked_clr, head_we;
  lqm_pkg::elem_t  head_wd;
  logic            present_set, present_clr, len_inc, len_dec, len_clr;
  logic            need_link;

  assign cur_present = present_q[qid_q];
  assign cur_head    = head_q[qid_q];
  assign cur_len     = len_q[qid_q];
  assign cur_linked  = linked_q[eid_q];

  // append reads the tail behind the head, remove reads the element's own back link
  assign prev_ra = (in_word_i.req_type == lqm_pkg::REQ_APPEND) ?
                   head_q[in_word_i.queue_id] : in_word_i.elem_id;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_word_i.req_type;
      qid_q <= in_word_i.queue_id;
      eid_q <= in_word_i.elem_id;
    end
  end

  always_comb begin
    nx_we       = 1'b0;
    nx_wa       = eid_q;
    nx_wd       = eid_q;
    pv_we       = 1'b0;
    pv_wa       = eid_q;
    pv_wd       = eid_q;
    ow_we       = 1'b0;
    linked_set  = 1'b0;
    linked_clr  = 1'b0;
    head_we     = 1'b0;
    head_wd     = eid_q;
    present_set = 1'b0;
    present_clr = 1'b0;
    len_inc     = 1'b0;
    len_dec     = 1'b0;
    len_clr     = 1'b0;
    need_link   = 1'b0;
    status_d    = lqm_pkg::STS_OK;
    if (cmd_i.exec) begin
      unique case (req_q)
        lqm_pkg::REQ_APPEND: begin
          if (cur_linked) begin
            status_d = lqm_pkg::STS_LINKED;
          end else begin
            linked_set = 1'b1;
            ow_we      = 1'b1;
            len_inc    = 1'b1;
            if (!cur_present) begin
              // sole entry: self-linked ring
              nx_we       = 1'b1;
              pv_we       = 1'b1;
              head_we     = 1'b1;
              present_set = 1'b1;
            end else begin
              // splice between tail and head; own links follow next cycle
              nx_we     = 1'b1;
              nx_wa     = prev_rd_q;
              pv_we     = 1'b1;
              pv_wa     = cur_head;
              need_link = 1'b1;
            end
          end
        end
        lqm_pkg::REQ_REMOVE: begin
          if (!cur_present) begin
            status_d = lqm_pkg::STS_EMPTY;
          end else if (!cur_linked || (owner_rd_q != qid_q)) begin
            status_d = lqm_pkg::STS_ABSENT;
          end else begin
            linked_clr = 1'b1;
            if (cur_len <= lqm_pkg::len_t'(1)) begin
              present_clr = 1'b1;
              len_clr     = 1'b1;
            end else begin
              if (cur_head == eid_q) begin
                head_we = 1'b1;
                head_wd = next_rd_q;
              end
              nx_we   = 1'b1;
              nx_wa   = prev_rd_q;
              nx_wd   = next_rd_q;
              pv_we   = 1'b1;
              pv_wa   = next_rd_q;
              pv_wd   = prev_rd_q;
              len_dec = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.link) begin
      nx_we = 1'b1;
      nx_wd = cur_head;
      pv_we = 1'b1;
      pv_wd = prev_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd_i.load) next_rd_q <= next_mem[in_word_i.elem_id];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd_i.load) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ow_we) owner_mem[eid_q] <= qid_q;
    if (cmd_i.load) owner_rd_q <= owner_mem[in_word_i.elem_id];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q <= '0;
    end else if (linked_set) begin
      linked_q[eid_q] <= 1'b1;
    end else if (linked_clr) begin
      linked_q[eid_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_q[qid_q] <= head_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      for (int i = 0; i < lqm_pkg::NumQueues; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      if (present_set) present_q[qid_q] <= 1'b1;
      else if (present_clr) present_q[qid_q] <= 1'b0;
      if (len_clr) len_q[qid_q] <= '0;
      else if (len_inc) len_q[qid_q] <= cur_len + lqm_pkg::len_t'(1);
      else if (len_dec) len_q[qid_q] <= cur_len - lqm_pkg::len_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_q.status       <= status_q;
      out_q.queue_length <= cur_len;
      out_q.head_elem    <= cur_present ? cur_head : '0;
      out_q.head_valid   <= cur_present;
    end
  end

  assign sts_o.need_link = need_link;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;

endmodule

FILE: sv/linked_queue_manager.sv
// Top level of the linked queue manager: sequencer plus datapath.
//
// Keeps 64 elements, named by index, on 4 circular doubly linked queues.
// Each input word is one request (append, remove or size) and gives exactly
// one result word: status, queue length after the request and the head.
// Requests are handled one at a time. A request goes from accept to the
// result register in steps (accept with the link memory reads, update,
// result load); an append to a non-empty queue adds a link step, as the
// next and previous link memories each have one write port and the tail
// splice needs two writes to each. A further request is taken the cycle
// after the result is loaded, even while it waits downstream; the result
// register only holds the sequencer back when a second result is ready
// before the first has gone. Membership is checked with a per-element
// linked flag (cleared at reset) and an owner tag held in memory; link and
// owner entries are only read behind a set linked flag, so they need no
// clearing after reset. Request code 3 behaves as a size request. An empty
// queue reports head 0 with head_valid low.
module linked_queue_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lqm_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lqm_pkg::out_word_t  out_word_o
);

  lqm_pkg::cmd_t cmd;
  lqm_pkg::sts_t sts;

  lqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lqm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
